### rtl/sat_pkg.sv
package sat_pkg;

  localparam int SUM_W     = 32;
  localparam int CELL_W    = 16;
  localparam int COORD_W   = 8;
  localparam int DIM_W     = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [SUM_W-1:0] word_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_RECT  = 2'd1,
    ST_NOT_READY = 2'd2
  } status_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD1,
    S_LD2,
    S_QA,
    S_QB,
    S_QC,
    S_QD
  } state_e;

endpackage

### rtl/summed_area_table_unit.sv
// channel   direction  handshake                          payload
// command   in         start_i & !busy_o                  operation_i, cell_value_i,
//                                                         top_row_i, left_col_i,
//                                                         bottom_row_i, right_col_i
// result    out        result_valid_o, one cycle          rect_sum_o, status_o
// config    in         cfg_valid_i & cfg_ready_o          cfg_index_i, cfg_data_i
//
// a load steps through accept, running-sum add, then prefix add and table write;
// both adds go through the one shared adder.
// a valid query reads four table corners over the two read ports and combines
// them in three adder passes; a rejected query reports in the next cycle.
// reset clears the load position, running sum and ready flag; the table itself
// is not cleared. results cannot be stalled; cfg_ready_o is always high.
module summed_area_table_unit
  import sat_pkg::*;
#(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        operation_i,
  input  logic signed [CELL_W-1:0]    cell_value_i,
  input  logic        [COORD_W-1:0]   top_row_i,
  input  logic        [COORD_W-1:0]   left_col_i,
  input  logic        [COORD_W-1:0]   bottom_row_i,
  input  logic        [COORD_W-1:0]   right_col_i,
  output logic                        result_valid_o,
  output logic signed [SUM_W-1:0]     rect_sum_o,
  output logic        [1:0]           status_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic        [CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [DIM_W-1:0]     cfg_data_i
);

  localparam int DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int AW      = $clog2(DEPTH);
  localparam int DIM_MAX = (1 << DIM_W) - 1;
  localparam int RowsCap = (MAX_ROWS > DIM_MAX) ? DIM_MAX : MAX_ROWS;
  localparam int ColsCap = (MAX_COLS > DIM_MAX) ? DIM_MAX : MAX_COLS;
  localparam logic [AW-1:0] ColStride = AW'(MAX_COLS);

  function automatic logic [AW-1:0] cell_addr(input logic [DIM_W-1:0] row,
                                              input logic [DIM_W-1:0] col);
    return AW'(row) * ColStride + AW'(col);
  endfunction

  state_e state_q, state_d;

  logic [DIM_W-1:0] row_cfg_q, col_cfg_q;
  logic [DIM_W-1:0] rows_used, cols_used;
  logic [DIM_W-1:0] load_row_q, load_col_q;
  logic [DIM_W-1:0] eff_row, eff_col;
  logic             out_of_range;
  logic             table_ready_q;
  word_t            running_q;
  logic             result_valid_q;

  logic [CELL_W-1:0]  cell_q;
  logic [COORD_W-1:0] top_q, left_q, bottom_q, right_q;
  word_t              acc_q;
  word_t              sum_q;
  status_e            status_q;
  status_e            query_status;

  logic accept, cfg_write;

  alu_op_e alu_op;
  word_t   alu_a, alu_b, alu_y;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr0, mem_raddr1;
  word_t         mem_rdata0, mem_rdata1;

  logic [DIM_W-1:0] above_row, top_m1, left_m1;
  logic             top_zero, left_zero, last_col, last_row;

  assign accept    = start_i && (state_q == S_IDLE);
  assign cfg_write = cfg_valid_i && cfg_ready_o;

  assign busy_o         = (state_q != S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = result_valid_q;
  assign rect_sum_o     = sum_q;
  assign status_o       = status_q;

  // clamp the register values to the usable grid
  always_comb begin
    if (row_cfg_q == '0) begin
      rows_used = DIM_W'(1);
    end else if (int'(row_cfg_q) > RowsCap) begin
      rows_used = DIM_W'(RowsCap);
    end else begin
      rows_used = row_cfg_q;
    end
    if (col_cfg_q == '0) begin
      cols_used = DIM_W'(1);
    end else if (int'(col_cfg_q) > ColsCap) begin
      cols_used = DIM_W'(ColsCap);
    end else begin
      cols_used = col_cfg_q;
    end
  end

  assign out_of_range = (load_row_q >= rows_used) || (load_col_q >= cols_used);
  assign eff_row      = out_of_range ? '0 : load_row_q;
  assign eff_col      = out_of_range ? '0 : load_col_q;
  assign last_col     = (load_col_q >= cols_used - DIM_W'(1));
  assign last_row     = (load_row_q >= rows_used - DIM_W'(1));
  assign above_row    = (load_row_q == '0) ? '0 : load_row_q - DIM_W'(1);

  assign top_zero  = (top_q == '0);
  assign left_zero = (left_q == '0);
  assign top_m1    = top_zero  ? '0 : DIM_W'(top_q)  - DIM_W'(1);
  assign left_m1   = left_zero ? '0 : DIM_W'(left_q) - DIM_W'(1);

  // not-ready is checked before the bounds
  always_comb begin
    if (!table_ready_q) begin
      query_status = ST_NOT_READY;
    end else if ((top_row_i > bottom_row_i) || (left_col_i > right_col_i) ||
                 (DIM_W'(bottom_row_i) >= rows_used) ||
                 (DIM_W'(right_col_i) >= cols_used)) begin
      query_status = ST_BAD_RECT;
    end else begin
      query_status = ST_OK;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (operation_i == OP_LOAD) begin
            state_d = S_LD1;
          end else if (query_status == ST_OK) begin
            state_d = S_QA;
          end
        end
      end
      S_LD1:   state_d = S_LD2;
      S_LD2:   state_d = S_IDLE;
      S_QA:    state_d = S_QB;
      S_QB:    state_d = S_QC;
      S_QC:    state_d = S_QD;
      S_QD:    state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath control: adder operands, table ports
  always_comb begin
    alu_op     = ALU_ADD;
    alu_a      = '0;
    alu_b      = '0;
    mem_we     = 1'b0;
    mem_waddr  = cell_addr(load_row_q, load_col_q);
    mem_raddr0 = cell_addr(above_row, load_col_q);
    mem_raddr1 = cell_addr(top_m1, left_m1);
    case (state_q)
      S_LD1: begin
        alu_a = running_q;
        alu_b = {{(SUM_W-CELL_W){cell_q[CELL_W-1]}}, cell_q};
      end
      S_LD2: begin
        alu_a  = running_q;
        alu_b  = (load_row_q == '0) ? '0 : mem_rdata0;
        mem_we = 1'b1;
      end
      S_QA: begin
        // corners at the bottom-right and above the top-right
        mem_raddr0 = cell_addr(DIM_W'(bottom_q), DIM_W'(right_q));
        mem_raddr1 = cell_addr(top_m1, DIM_W'(right_q));
      end
      S_QB: begin
        alu_op     = ALU_SUB;
        alu_a      = mem_rdata0;
        alu_b      = top_zero ? '0 : mem_rdata1;
        mem_raddr0 = cell_addr(DIM_W'(bottom_q), left_m1);
      end
      S_QC: begin
        alu_op     = ALU_SUB;
        alu_a      = acc_q;
        alu_b      = left_zero ? '0 : mem_rdata0;
        mem_raddr0 = cell_addr(DIM_W'(bottom_q), left_m1);
      end
      S_QD: begin
        alu_a      = acc_q;
        alu_b      = (top_zero || left_zero) ? '0 : mem_rdata1;
        mem_raddr0 = cell_addr(DIM_W'(bottom_q), left_m1);
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  sat_alu u_alu (
    .op_i (alu_op),
    .a_i  (alu_a),
    .b_i  (alu_b),
    .y_o  (alu_y)
  );

  sat_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wdata_i  (alu_y),
    .raddr0_i (mem_raddr0),
    .raddr1_i (mem_raddr1),
    .rdata0_o (mem_rdata0),
    .rdata1_o (mem_rdata1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      row_cfg_q      <= DIM_RESET;
      col_cfg_q      <= DIM_RESET;
      load_row_q     <= '0;
      load_col_q     <= '0;
      running_q      <= '0;
      table_ready_q  <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= 1'b0;
      if (cfg_write) begin
        // a row or column count write restarts loading
        if (cfg_index_i == REG_ROW_COUNT) begin
          row_cfg_q <= cfg_data_i;
        end
        if (cfg_index_i == REG_COL_COUNT) begin
          col_cfg_q <= cfg_data_i;
        end
        if ((cfg_index_i == REG_ROW_COUNT) || (cfg_index_i == REG_COL_COUNT)) begin
          load_row_q    <= '0;
          load_col_q    <= '0;
          running_q     <= '0;
          table_ready_q <= 1'b0;
        end
      end else begin
        case (state_q)
          S_IDLE: begin
            if (accept) begin
              if (operation_i == OP_LOAD) begin
                load_row_q <= eff_row;
                load_col_q <= eff_col;
                if (out_of_range) begin
                  running_q <= '0;
                end
                // first cell of a new grid
                if ((eff_row == '0) && (eff_col == '0)) begin
                  table_ready_q <= 1'b0;
                end
              end else if (query_status != ST_OK) begin
                result_valid_q <= 1'b1;
              end
            end
          end
          S_LD1: begin
            running_q <= alu_y;
          end
          S_LD2: begin
            if (last_col) begin
              load_col_q <= '0;
              running_q  <= '0;
              if (last_row) begin
                load_row_q    <= '0;
                table_ready_q <= 1'b1;
              end else begin
                load_row_q <= load_row_q + DIM_W'(1);
              end
            end else begin
              load_col_q <= load_col_q + DIM_W'(1);
            end
          end
          S_QD: begin
            result_valid_q <= 1'b1;
          end
          default: begin
            running_q <= running_q;
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cell_q   <= cell_value_i;
          top_q    <= top_row_i;
          left_q   <= left_col_i;
          bottom_q <= bottom_row_i;
          right_q  <= right_col_i;
          if (operation_i == OP_QUERY) begin
            status_q <= query_status;
            sum_q    <= '0;
          end
        end
      end
      S_QB, S_QC: begin
        acc_q <= alu_y;
      end
      S_QD: begin
        sum_q    <= alu_y;
        status_q <= ST_OK;
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

endmodule

### rtl/sat_alu.sv
module sat_alu
  import sat_pkg::*;
(
  input  alu_op_e op_i,
  input  word_t   a_i,
  input  word_t   b_i,
  output word_t   y_o
);

  // sums wrap modulo 2^32
  always_comb begin
    case (op_i)
      ALU_ADD: y_o = a_i + b_i;
      ALU_SUB: y_o = a_i - b_i;
      default: y_o = a_i + b_i;
    endcase
  end

endmodule

### rtl/sat_mem.sv
module sat_mem
  import sat_pkg::*;
#(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  word_t         wdata_i,
  input  logic [AW-1:0] raddr0_i,
  input  logic [AW-1:0] raddr1_i,
  output word_t         rdata0_o,
  output word_t         rdata1_o
);

  word_t mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

### rtl/sat_checker.sv
module sat_checker
  import sat_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start_i,
  input logic                    busy_o,
  input logic                    operation_i,
  input logic                    result_valid_o,
  input logic signed [SUM_W-1:0] rect_sum_o,
  input logic        [1:0]       status_o,
  input logic                    cfg_valid_i,
  input logic                    cfg_ready_o
);

  logic load_req, query_req;

  assign load_req  = start_i && !busy_o && (operation_i == OP_LOAD);
  assign query_req = start_i && !busy_o && (operation_i == OP_QUERY);

  // a rejected query always reports a zero sum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o != ST_OK)) |-> (rect_sum_o == '0))
    else $error("error result with nonzero sum");

  // a load request produces no result and keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_req |=> (busy_o && !result_valid_o))
    else $error("load request not processed as a load");

  // a query request either reports at once or starts the table reads
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_req |=> (busy_o != result_valid_o))
    else $error("query request lost");

  // a result is shown only once the sequencer is back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result strobe while busy");

  // the configuration port never holds off a write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write stalled");

endmodule

bind summed_area_table_unit sat_checker u_sat_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .operation_i    (operation_i),
  .result_valid_o (result_valid_o),
  .rect_sum_o     (rect_sum_o),
  .status_o       (status_o),
  .cfg_valid_i    (cfg_valid_i),
  .cfg_ready_o    (cfg_ready_o)
);

### tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sat_pkg::*;

  localparam int GRID_DIM      = 256;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 20;
  localparam int PHASE_ITEMS   = 40;
  localparam int NUM_PHASES    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // grid settings per phase; 0 and 511 exercise the clamping of the size registers
  localparam logic [DIM_W-1:0] PHASE_ROWS [NUM_PHASES] =
    '{9'd1, 9'd3, 9'd128, 9'd0, 9'd6, 9'd0,   9'd8, 9'd5};
  localparam logic [DIM_W-1:0] PHASE_COLS [NUM_PHASES] =
    '{9'd1, 9'd4, 9'd1,   9'd5, 9'd6, 9'd511, 9'd8, 9'd3};
  localparam int PHASE_IDLE [NUM_PHASES] = '{17, 17, 17, 62, 62, 62, 0, 0};

  typedef struct packed {
    word_t   sum;
    status_e status;
  } rect_result_t;

  class rect_sum_tracker;
    word_t            prefix_mem [GRID_DIM*GRID_DIM];
    logic [DIM_W-1:0] row_reg;
    logic [DIM_W-1:0] col_reg;
    int unsigned      load_r;
    int unsigned      load_c;
    word_t            run_sum;
    bit               grid_ready;
    rect_result_t     expected_q [$];
    int               mismatches;
    int               loads_seen;
    int               queries_seen;
    int               regs_written;
    int               status_seen [3];

    function new();
      row_reg = DIM_RESET;
      col_reg = DIM_RESET;
      restart_grid();
    endfunction

    function void restart_grid();
      run_sum    = '0;
      load_r     = 0;
      load_c     = 0;
      grid_ready = 1'b0;
    endfunction

    function int unsigned dim_in_use(logic [DIM_W-1:0] v);
      if (v == '0) return 1;
      if (v > GRID_DIM) return GRID_DIM;
      return 32'(v);
    endfunction

    function int unsigned rows_in_use();
      return dim_in_use(row_reg);
    endfunction

    function int unsigned cols_in_use();
      return dim_in_use(col_reg);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // prefix entry above and left of (r, c); zero outside the grid
    function word_t corner(int unsigned r, int unsigned c);
      if (r == 0 || c == 0) return '0;
      return prefix_mem[(r - 1) * GRID_DIM + c - 1];
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      regs_written++;
      if (idx == REG_ROW_COUNT) begin
        row_reg = data;
        restart_grid();
      end else if (idx == REG_COL_COUNT) begin
        col_reg = data;
        restart_grid();
      end
    endfunction

    function void note_request(logic op, logic [CELL_W-1:0] val,
                               logic [COORD_W-1:0] t, logic [COORD_W-1:0] l,
                               logic [COORD_W-1:0] b, logic [COORD_W-1:0] r);
      int unsigned  rows;
      int unsigned  cols;
      word_t        above;
      rect_result_t res;
      rows = rows_in_use();
      cols = cols_in_use();
      if (op == OP_LOAD) begin
        loads_seen++;
        if (load_r >= rows || load_c >= cols) begin
          load_r  = 0;
          load_c  = 0;
          run_sum = '0;
        end
        if (load_r == 0 && load_c == 0) grid_ready = 1'b0;
        run_sum = run_sum + {{(SUM_W-CELL_W){val[CELL_W-1]}}, val};
        above = (load_r == 0) ? '0 : prefix_mem[(load_r - 1) * GRID_DIM + load_c];
        prefix_mem[load_r * GRID_DIM + load_c] = run_sum + above;
        load_c++;
        if (load_c >= cols) begin
          load_c  = 0;
          run_sum = '0;
          load_r++;
          if (load_r >= rows) begin
            load_r     = 0;
            grid_ready = 1'b1;
          end
        end
      end else begin
        queries_seen++;
        res.sum = '0;
        if (!grid_ready) begin
          res.status = ST_NOT_READY;
        end else if (t > b || l > r || b >= rows || r >= cols) begin
          res.status = ST_BAD_RECT;
        end else begin
          res.status = ST_OK;
          res.sum = corner(32'(b) + 1, 32'(r) + 1) - corner(32'(t), 32'(r) + 1)
                  - corner(32'(b) + 1, 32'(l)) + corner(32'(t), 32'(l));
        end
        status_seen[res.status]++;
        expected_q.insert(expected_q.size(), res);
      end
    endfunction

    function void check_result(word_t sum, logic [1:0] status);
      rect_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with no query waiting: rect_sum %0d status %0d",
                   $time, $signed(sum), status);
        return;
      end
      want = expected_q.pop_front();
      if (sum !== want.sum) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: rect_sum mismatch: expected %0d actual %0d",
                   $time, $signed(want.sum), $signed(sum));
      end
      if (status !== want.status) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, want.status, status);
      end
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic                       operation_i;
  logic signed [CELL_W-1:0]   cell_value_i;
  logic        [COORD_W-1:0]  top_row_i;
  logic        [COORD_W-1:0]  left_col_i;
  logic        [COORD_W-1:0]  bottom_row_i;
  logic        [COORD_W-1:0]  right_col_i;
  logic                       result_valid_o;
  logic signed [SUM_W-1:0]    rect_sum_o;
  logic        [1:0]          status_o;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic        [CFG_IDX_W-1:0] cfg_index_i;
  logic        [DIM_W-1:0]    cfg_data_i;

  rect_sum_tracker tracker = new();
  int idle_pct = 0;
  int stall_cycles = 0;

  summed_area_table_unit DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) tracker.check_result(rect_sum_o, status_o);
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no request or result for %0d cycles", $time, STALL_LIMIT);
      $display("[summed_area_table_unit] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [CELL_W-1:0] pick_cell();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return CELL_W'($urandom);
    endcase
  endfunction

  task automatic send_request(input logic op, input logic [CELL_W-1:0] val,
                              input logic [COORD_W-1:0] t, input logic [COORD_W-1:0] l,
                              input logic [COORD_W-1:0] b, input logic [COORD_W-1:0] r);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i      <= 1'b1;
    operation_i  <= op;
    cell_value_i <= val;
    top_row_i    <= t;
    left_col_i   <= l;
    bottom_row_i <= b;
    right_col_i  <= r;
    do @(posedge clk_i); while (busy_o);
    tracker.note_request(op, val, t, l, b, r);
  endtask

  // coordinates are ignored on a load, so they carry noise
  task automatic load_cell(input logic [CELL_W-1:0] val);
    send_request(OP_LOAD, val, COORD_W'($urandom), COORD_W'($urandom),
                 COORD_W'($urandom), COORD_W'($urandom));
  endtask

  task automatic query_rect(input logic [COORD_W-1:0] t, input logic [COORD_W-1:0] l,
                            input logic [COORD_W-1:0] b, input logic [COORD_W-1:0] r);
    send_request(OP_QUERY, CELL_W'($urandom), t, l, b, r);
  endtask

  // mostly rectangles inside the grid, some with fully random corners
  task automatic send_query(input int unsigned rows, input int unsigned cols);
    logic [COORD_W-1:0] t, l, b, r;
    if ($urandom_range(0, 4) == 0) begin
      t = COORD_W'($urandom);
      l = COORD_W'($urandom);
      b = COORD_W'($urandom);
      r = COORD_W'($urandom);
    end else begin
      t = COORD_W'($urandom_range(0, rows - 1));
      b = COORD_W'($urandom_range(t, rows - 1));
      l = COORD_W'($urandom_range(0, cols - 1));
      r = COORD_W'($urandom_range(l, cols - 1));
    end
    query_rect(t, l, b, r);
  endtask

  task automatic load_grid(input int unsigned rows, input int unsigned cols);
    repeat (rows * cols) begin
      if ($urandom_range(0, 19) == 0) send_query(rows, cols);
      load_cell(pick_cell());
    end
  endtask

  // loads give no result, so allow the last one to finish before touching registers
  task automatic quiesce();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (tracker.pending() != 0 || busy_o) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_register(idx, data);
  endtask

  task automatic program_grid(input logic [DIM_W-1:0] rows_raw,
                              input logic [DIM_W-1:0] cols_raw);
    quiesce();
    write_reg(REG_ROW_COUNT, rows_raw);
    write_reg(REG_COL_COUNT, cols_raw);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned rows, cols, phase_start;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    operation_i  = OP_LOAD;
    cell_value_i = '0;
    top_row_i    = '0;
    left_col_i   = '0;
    bottom_row_i = '0;
    right_col_i  = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = REG_ROW_COUNT;
    cfg_data_i   = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // default 256x256 grid is far from complete, so queries report not loaded
    idle_pct = 17;
    query_rect(8'd0, 8'd0, 8'd255, 8'd255);
    load_cell(16'h8000);
    load_cell(16'h7fff);
    query_rect(8'd0, 8'd0, 8'd0, 8'd0);

    program_grid(9'd2, 9'd2);
    load_cell(16'h7fff);
    load_cell(16'h8000);
    load_cell(16'hffff);
    load_cell(16'd12345);
    query_rect(8'd0, 8'd0, 8'd1, 8'd1);
    query_rect(8'd1, 8'd1, 8'd1, 8'd1);
    query_rect(8'd0, 8'd1, 8'd0, 8'd1);
    query_rect(8'd1, 8'd0, 8'd1, 8'd0);
    query_rect(8'd1, 8'd0, 8'd0, 8'd1);
    query_rect(8'd0, 8'd1, 8'd1, 8'd0);
    query_rect(8'd0, 8'd0, 8'd2, 8'd1);
    query_rect(8'd0, 8'd0, 8'd1, 8'd2);
    query_rect(8'd255, 8'd255, 8'd255, 8'd255);
    // first load of a new grid drops the ready flag
    load_cell(pick_cell());
    query_rect(8'd0, 8'd0, 8'd0, 8'd0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_pct = PHASE_IDLE[p];
      program_grid(PHASE_ROWS[p], PHASE_COLS[p]);
      rows = tracker.rows_in_use();
      cols = tracker.cols_in_use();
      phase_start = tracker.loads_seen + tracker.queries_seen;
      do begin
        load_grid(rows, cols);
        repeat ((rows * cols > 64) ? 24 : $urandom_range(3, 8)) send_query(rows, cols);
      end while (tracker.loads_seen + tracker.queries_seen - phase_start < PHASE_ITEMS);

      // an unknown register index leaves the finished table alone
      quiesce();
      write_reg(REG_UNUSED, DIM_W'($urandom));
      @(negedge clk_i);
      cfg_valid_i <= 1'b0;
      repeat (3) send_query(rows, cols);

      // leave a grid partly loaded so the next register write has to restart it
      if (rows * cols > 1 && $urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, (rows * cols > 8) ? 8 : rows * cols - 1))
          load_cell(pick_cell());
        send_query(rows, cols);
      end
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d loads and %0d queries with %0d register writes, grids 1x1 to 1x256",
             tracker.loads_seen, tracker.queries_seen, tracker.regs_written);
    $display("query outcomes: %0d ok, %0d bad rectangle, %0d table not loaded",
             tracker.status_seen[ST_OK], tracker.status_seen[ST_BAD_RECT],
             tracker.status_seen[ST_NOT_READY]);
    if (tracker.mismatches == 0) begin
      $display("[summed_area_table_unit] OK");
    end else begin
      $display("[summed_area_table_unit] ERROR");
    end
    $finish;
  end

endmodule

### summed_area_table_unit.f
rtl/sat_pkg.sv
rtl/sat_alu.sv
rtl/sat_mem.sv
rtl/summed_area_table_unit.sv
rtl/sat_checker.sv
tb/sv/tb_top.sv
